FILE: rtl/core/sepf_pkg.sv
// Package: codes, result word type and CRC-16 byte update for the packet framer.
`timescale 1ns / 1ps

package sepf_pkg;

    localparam logic [1:0] FUNC_START_CMD = 2'd0;
    localparam logic [1:0] FUNC_CMD_DATA  = 2'd1;
    localparam logic [1:0] FUNC_START_RSP = 2'd2;
    localparam logic [1:0] FUNC_RSP_BYTE  = 2'd3;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_RSP    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_COUNT_ERR = 2'd1;
    localparam logic [1:0] STATUS_CRC_ERR   = 2'd2;

    localparam logic [15:0] CRC_POLY      = 16'h8005;
    localparam logic [7:0]  WORD_ADDR_CMD = 8'h03;
    localparam logic [7:0]  CMD_OVERHEAD  = 8'd7;
    localparam logic [7:0]  RSP_OVERHEAD  = 8'd3;

    localparam int RES_DEPTH = 8;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
    } t_result;

    // one byte, LSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            if (b[k] != c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/sepf_if.sv
// Interfaces: request and result channels of the packet framer.
`timescale 1ns / 1ps

interface sepf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  opcode;
    logic [7:0]  param_one;
    logic [15:0] param_two;
    logic [6:0]  data_len;
    logic [6:0]  resp_len;
    logic [7:0]  in_byte;

    modport source (output valid, func, opcode, param_one, param_two, data_len, resp_len,
                    in_byte, input ready);
    modport sink   (input valid, func, opcode, param_one, param_two, data_len, resp_len,
                    in_byte, output ready);
endinterface

interface sepf_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;

    modport source (output valid, kind, out_byte, status, last, input ready);
    modport sink   (input valid, kind, out_byte, status, last, output ready);
endinterface

FILE: rtl/core/secure_element_packet_framer_core.sv
// Top level: command packet framer with CRC-16 and response checker.
//
//   channel  dir  modport  words
//   i_req    in   sink     func, opcode, param_one, param_two, data_len, resp_len, in_byte
//   o_res    out  source   kind, out_byte, status, last
//
// A request word is decoded in the cycle it is accepted; its results (0 to 8) go to a
// result buffer that drains one word per cycle while o_res.ready is high. A word with one
// result or none is taken every cycle unless o_res.ready stalls; a start command holds the
// input while its 6 or 8 head bytes drain, a closing data word while its 3 bytes drain.
// i_req.ready rises in the cycle the last buffered result is taken.
// i_rst_n (synchronous, active low) clears the CRC, counters and buffer state.
`timescale 1ns / 1ps

module secure_element_packet_framer_core
    import sepf_pkg::*;
#(
    parameter int MAX_DATA = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sepf_req_if.sink   i_req,
    sepf_res_if.source o_res
);

    logic [15:0] r_crc, n_crc;
    logic [6:0]  r_tx_rem, n_tx_rem;
    logic [6:0]  r_rx_exp, n_rx_exp;
    logic [6:0]  r_rx_pos, n_rx_pos;
    logic [7:0]  r_rx_cnt_byte, n_rx_cnt_byte;
    logic [7:0]  r_rx_crc_lo, n_rx_crc_lo;
    logic        r_rx_busy, n_rx_busy;

    t_result     r_buf [RES_DEPTH];
    t_result     n_res [RES_DEPTH];
    logic [3:0]  r_cnt, r_idx, n_num;

    logic        in_fire, out_fire, buf_empty, buf_final;
    logic [7:0]  count_b, p2_lo, p2_hi;
    logic [15:0] crc_c, crc_o, crc_p, crc_l, crc_h, crc_d, rx_got;
    logic [6:0]  tx_dec;
    t_result     cur;

    assign buf_empty = (r_idx == r_cnt);
    assign buf_final = (r_idx + 4'd1 == r_cnt);
    assign cur       = r_buf[r_idx[2:0]];

    assign o_res.valid    = !buf_empty;
    assign o_res.kind     = cur.kind;
    assign o_res.out_byte = cur.out_byte;
    assign o_res.status   = cur.status;
    assign o_res.last     = cur.last;

    assign i_req.ready = buf_empty || (buf_final && o_res.ready);
    assign in_fire     = i_req.valid && i_req.ready;
    assign out_fire    = o_res.valid && o_res.ready;

    // command head CRC, per-byte CRC update and received CRC word
    assign count_b = CMD_OVERHEAD + {1'b0, i_req.data_len};
    assign p2_lo   = i_req.param_two[7:0];
    assign p2_hi   = i_req.param_two[15:8];
    assign crc_c   = crc_feed(16'h0000, count_b);
    assign crc_o   = crc_feed(crc_c, i_req.opcode);
    assign crc_p   = crc_feed(crc_o, i_req.param_one);
    assign crc_l   = crc_feed(crc_p, p2_lo);
    assign crc_h   = crc_feed(crc_l, p2_hi);
    assign crc_d   = crc_feed(r_crc, i_req.in_byte);
    assign tx_dec  = r_tx_rem - 7'd1;
    assign rx_got  = {i_req.in_byte, r_rx_crc_lo};

    always_comb begin
        n_crc         = r_crc;
        n_tx_rem      = r_tx_rem;
        n_rx_exp      = r_rx_exp;
        n_rx_pos      = r_rx_pos;
        n_rx_cnt_byte = r_rx_cnt_byte;
        n_rx_crc_lo   = r_rx_crc_lo;
        n_rx_busy     = r_rx_busy;
        n_num         = 4'd0;
        for (int k = 0; k < RES_DEPTH; k++) begin
            n_res[k] = '{kind: KIND_TX, out_byte: 8'h00, status: STATUS_OK, last: 1'b0};
        end
        unique case (i_req.func)
            FUNC_START_CMD: begin
                if ({25'd0, i_req.data_len} <= MAX_DATA) begin
                    n_rx_busy = 1'b0;
                    n_crc     = crc_h;
                    n_tx_rem  = i_req.data_len;
                    n_res[0].out_byte = WORD_ADDR_CMD;
                    n_res[1].out_byte = count_b;
                    n_res[2].out_byte = i_req.opcode;
                    n_res[3].out_byte = i_req.param_one;
                    n_res[4].out_byte = p2_lo;
                    n_res[5].out_byte = p2_hi;
                    n_num = 4'd6;
                    if (i_req.data_len == 7'd0) begin
                        n_res[6].out_byte = crc_h[7:0];
                        n_res[7].out_byte = crc_h[15:8];
                        n_res[7].last     = 1'b1;
                        n_num = 4'd8;
                    end
                end
            end
            FUNC_CMD_DATA: begin
                if (r_tx_rem != 7'd0) begin
                    n_crc    = crc_d;
                    n_tx_rem = tx_dec;
                    n_res[0].out_byte = i_req.in_byte;
                    n_num = 4'd1;
                    if (tx_dec == 7'd0) begin
                        n_res[1].out_byte = crc_d[7:0];
                        n_res[2].out_byte = crc_d[15:8];
                        n_res[2].last     = 1'b1;
                        n_num = 4'd3;
                    end
                end
            end
            FUNC_START_RSP: begin
                if ({25'd0, i_req.resp_len} <= MAX_DATA) begin
                    n_tx_rem      = 7'd0;
                    n_crc         = 16'h0000;
                    n_rx_exp      = i_req.resp_len;
                    n_rx_pos      = 7'd0;
                    n_rx_cnt_byte = 8'h00;
                    n_rx_crc_lo   = 8'h00;
                    n_rx_busy     = 1'b1;
                end
            end
            FUNC_RSP_BYTE: begin
                if (r_rx_busy) begin
                    n_rx_pos = r_rx_pos + 7'd1;
                    priority if (r_rx_pos == 7'd0) begin
                        n_rx_cnt_byte = i_req.in_byte;
                        n_crc         = crc_d;
                    end else if (r_rx_pos <= r_rx_exp) begin
                        n_crc = crc_d;
                        n_res[0].kind     = KIND_RSP;
                        n_res[0].out_byte = i_req.in_byte;
                        n_num = 4'd1;
                    end else if (r_rx_pos == r_rx_exp + 7'd1) begin
                        n_rx_crc_lo = i_req.in_byte;
                    end else begin
                        n_res[0].kind = KIND_STATUS;
                        n_res[0].last = 1'b1;
                        if (r_rx_cnt_byte != {1'b0, r_rx_exp} + RSP_OVERHEAD) begin
                            n_res[0].status = STATUS_COUNT_ERR;
                        end else if (rx_got != r_crc) begin
                            n_res[0].status = STATUS_CRC_ERR;
                        end
                        n_num     = 4'd1;
                        n_rx_busy = 1'b0;
                        n_rx_pos  = 7'd0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc         <= 16'h0000;
            r_tx_rem      <= 7'd0;
            r_rx_exp      <= 7'd0;
            r_rx_pos      <= 7'd0;
            r_rx_cnt_byte <= 8'h00;
            r_rx_crc_lo   <= 8'h00;
            r_rx_busy     <= 1'b0;
            r_cnt         <= 4'd0;
            r_idx         <= 4'd0;
        end else begin
            if (in_fire) begin
                r_crc         <= n_crc;
                r_tx_rem      <= n_tx_rem;
                r_rx_exp      <= n_rx_exp;
                r_rx_pos      <= n_rx_pos;
                r_rx_cnt_byte <= n_rx_cnt_byte;
                r_rx_crc_lo   <= n_rx_crc_lo;
                r_rx_busy     <= n_rx_busy;
            end
            if (in_fire && n_num != 4'd0) begin
                r_cnt <= n_num;
                r_idx <= 4'd0;
            end else if (out_fire) begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && n_num != 4'd0) begin
            for (int k = 0; k < RES_DEPTH; k++) begin
                r_buf[k] <= n_res[k];
            end
        end
    end

endmodule

FILE: tb/tb_secure_element_packet_framer_core.sv
// Testbench: command framing and response checks of the packet framer, against a local model.
`timescale 1ns / 1ps

module tb_secure_element_packet_framer_core;
    import sepf_pkg::*;

    localparam int SE_MAX_DATA = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 16;
    localparam int FULL        = 255;

    localparam int FLAW_NONE  = 0;
    localparam int FLAW_COUNT = 1;
    localparam int FLAW_CRC   = 2;
    localparam int FLAW_BOTH  = 3;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  opcode;
        logic [7:0]  param_one;
        logic [15:0] param_two;
        logic [6:0]  data_len;
        logic [6:0]  resp_len;
        logic [7:0]  in_byte;
    } t_req_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sepf_req_if req_ch ();
    sepf_res_if res_ch ();

    secure_element_packet_framer_core #(
        .MAX_DATA(SE_MAX_DATA)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    always #5 i_clk = ~i_clk;

    t_req_word req_backlog[$];
    t_result   owed_results[$];
    t_req_word cur_word;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        mismatches = 0;
    int        quiet_cycles = 0;

    // framer model state
    logic [15:0] crc_acc     = '0;
    logic [6:0]  tx_owed     = '0;
    logic [6:0]  rx_len      = '0;
    logic [6:0]  rx_pos      = '0;
    logic [7:0]  rx_cnt_byte = '0;
    logic [7:0]  rx_crc_lo   = '0;
    logic        rx_armed    = 1'b0;

    function automatic bit roll(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // CRC-16 0x8005, one byte LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        int   k;
        for (k = 0; k < 8; k++) begin
            fb = b[k] ^ c[15];
            c  = {c[14:0], 1'b0} ^ ({16{fb}} & CRC_POLY);
        end
        return c;
    endfunction

    task automatic owe(input logic [1:0] kind, input logic [7:0] b, input logic [1:0] st,
                       input logic last);
        t_result r;
        r.kind     = kind;
        r.out_byte = b;
        r.status   = st;
        r.last     = last;
        owed_results.push_back(r);
    endtask

    task automatic owe_crc();
        owe(KIND_TX, crc_acc[7:0], STATUS_OK, 1'b0);
        owe(KIND_TX, crc_acc[15:8], STATUS_OK, 1'b1);
    endtask

    task automatic advance_framer(input t_req_word w);
        logic [7:0]  cnt;
        logic [15:0] got;
        logic [1:0]  st;
        case (w.func)
            FUNC_START_CMD: begin
                if (int'(w.data_len) <= SE_MAX_DATA) begin
                    rx_armed = 1'b0;
                    cnt      = CMD_OVERHEAD + {1'b0, w.data_len};
                    crc_acc  = crc16_byte(16'h0000, cnt);
                    crc_acc  = crc16_byte(crc_acc, w.opcode);
                    crc_acc  = crc16_byte(crc_acc, w.param_one);
                    crc_acc  = crc16_byte(crc_acc, w.param_two[7:0]);
                    crc_acc  = crc16_byte(crc_acc, w.param_two[15:8]);
                    owe(KIND_TX, WORD_ADDR_CMD, STATUS_OK, 1'b0);
                    owe(KIND_TX, cnt, STATUS_OK, 1'b0);
                    owe(KIND_TX, w.opcode, STATUS_OK, 1'b0);
                    owe(KIND_TX, w.param_one, STATUS_OK, 1'b0);
                    owe(KIND_TX, w.param_two[7:0], STATUS_OK, 1'b0);
                    owe(KIND_TX, w.param_two[15:8], STATUS_OK, 1'b0);
                    tx_owed = w.data_len;
                    if (tx_owed == 7'd0) owe_crc();
                end
            end
            FUNC_CMD_DATA: begin
                if (tx_owed != 7'd0) begin
                    crc_acc = crc16_byte(crc_acc, w.in_byte);
                    owe(KIND_TX, w.in_byte, STATUS_OK, 1'b0);
                    tx_owed = tx_owed - 7'd1;
                    if (tx_owed == 7'd0) owe_crc();
                end
            end
            FUNC_START_RSP: begin
                if (int'(w.resp_len) <= SE_MAX_DATA) begin
                    tx_owed     = '0;
                    crc_acc     = '0;
                    rx_len      = w.resp_len;
                    rx_pos      = '0;
                    rx_cnt_byte = '0;
                    rx_crc_lo   = '0;
                    rx_armed    = 1'b1;
                end
            end
            default: begin
                if (rx_armed) begin
                    if (rx_pos == 7'd0) begin
                        rx_cnt_byte = w.in_byte;
                        crc_acc     = crc16_byte(crc_acc, w.in_byte);
                        rx_pos      = rx_pos + 7'd1;
                    end else if (rx_pos <= rx_len) begin
                        crc_acc = crc16_byte(crc_acc, w.in_byte);
                        owe(KIND_RSP, w.in_byte, STATUS_OK, 1'b0);
                        rx_pos = rx_pos + 7'd1;
                    end else if (rx_pos == rx_len + 7'd1) begin
                        rx_crc_lo = w.in_byte;
                        rx_pos    = rx_pos + 7'd1;
                    end else begin
                        got = {w.in_byte, rx_crc_lo};
                        if (rx_cnt_byte != {1'b0, rx_len} + RSP_OVERHEAD) st = STATUS_COUNT_ERR;
                        else if (got != crc_acc) st = STATUS_CRC_ERR;
                        else st = STATUS_OK;
                        owe(KIND_STATUS, 8'h00, st, 1'b1);
                        rx_armed = 1'b0;
                        rx_pos   = '0;
                    end
                end
            end
        endcase
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) advance_framer(cur_word);
            if (!req_ch.valid || req_ch.ready) begin
                if (req_backlog.size() != 0 && !roll(send_idle_pct)) begin
                    cur_word            = req_backlog.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.func        <= cur_word.func;
                    req_ch.opcode      <= cur_word.opcode;
                    req_ch.param_one   <= cur_word.param_one;
                    req_ch.param_two   <= cur_word.param_two;
                    req_ch.data_len    <= cur_word.data_len;
                    req_ch.resp_len    <= cur_word.resp_len;
                    req_ch.in_byte     <= cur_word.in_byte;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result sink back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= !roll(recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // result monitor
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (owed_results.size() == 0) begin
                $error("unexpected result word: kind %0d byte %0d status %0d last %0d",
                       res_ch.kind, res_ch.out_byte, res_ch.status, res_ch.last);
                mismatches++;
            end else begin
                want = owed_results.pop_front();
                check_field("kind", int'(want.kind), int'(res_ch.kind));
                check_field("out_byte", int'(want.out_byte), int'(res_ch.out_byte));
                check_field("status", int'(want.status), int'(res_ch.status));
                check_field("last", int'(want.last), int'(res_ch.last));
            end
        end
    end

    // watchdog: no word moved while work is pending
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (!req_ch.valid && req_backlog.size() == 0 && owed_results.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_req_word mk_word(input logic [1:0] f);
        t_req_word w;
        w.func      = f;
        w.opcode    = 8'($urandom);
        w.param_one = 8'($urandom);
        w.param_two = 16'($urandom);
        w.data_len  = 7'($urandom);
        w.resp_len  = 7'($urandom);
        w.in_byte   = 8'($urandom);
        return w;
    endfunction

    task automatic queue_cmd(input logic [7:0] op, input logic [7:0] p1, input logic [15:0] p2,
                             input logic [6:0] dlen, input int ndata);
        t_req_word w;
        int        i;
        w           = mk_word(FUNC_START_CMD);
        w.opcode    = op;
        w.param_one = p1;
        w.param_two = p2;
        w.data_len  = dlen;
        req_backlog.push_back(w);
        for (i = 0; i < ndata; i++) req_backlog.push_back(mk_word(FUNC_CMD_DATA));
    endtask

    task automatic queue_rsp(input logic [6:0] rlen, input int flaw, input int keep);
        t_req_word   w;
        logic [7:0]  frame[$];
        logic [15:0] c;
        logic [7:0]  cnt;
        logic [7:0]  b;
        int          i;
        w          = mk_word(FUNC_START_RSP);
        w.resp_len = rlen;
        req_backlog.push_back(w);
        cnt = {1'b0, rlen} + RSP_OVERHEAD;
        if (flaw == FLAW_COUNT || flaw == FLAW_BOTH) cnt = cnt ^ (8'd1 << $urandom_range(0, 7));
        frame.push_back(cnt);
        c = crc16_byte(16'h0000, cnt);
        for (i = 0; i < int'(rlen); i++) begin
            b = 8'($urandom);
            frame.push_back(b);
            c = crc16_byte(c, b);
        end
        if (flaw == FLAW_CRC || flaw == FLAW_BOTH) c = c ^ (16'd1 << $urandom_range(0, 15));
        frame.push_back(c[7:0]);
        frame.push_back(c[15:8]);
        for (i = 0; i < keep && i < frame.size(); i++) begin
            w         = mk_word(FUNC_RSP_BYTE);
            w.in_byte = frame[i];
            req_backlog.push_back(w);
        end
    endtask

    task automatic queue_directed();
        t_req_word w;
        queue_cmd(8'hFF, 8'h00, 16'hFFFF, 7'd0, 0);
        queue_cmd(8'h00, 8'hFF, 16'h0000, 7'd2, 0);
        w = mk_word(FUNC_CMD_DATA);
        w.in_byte = 8'h00;
        req_backlog.push_back(w);
        w.in_byte = 8'hFF;
        req_backlog.push_back(w);
        // stray data and response words, nothing owed or armed
        req_backlog.push_back(mk_word(FUNC_CMD_DATA));
        req_backlog.push_back(mk_word(FUNC_RSP_BYTE));
        // oversized lengths are dropped
        w = mk_word(FUNC_START_CMD);
        w.data_len = 7'd65;
        req_backlog.push_back(w);
        w = mk_word(FUNC_START_RSP);
        w.resp_len = 7'd127;
        req_backlog.push_back(w);
        queue_rsp(7'd0, FLAW_NONE, FULL);
        // response start cuts off a long command; count error must win over CRC error
        queue_cmd(8'($urandom), 8'($urandom), 16'($urandom), 7'd64, 3);
        queue_rsp(7'd1, FLAW_BOTH, FULL);
        // command start aborts an armed response
        queue_rsp(7'd2, FLAW_NONE, 2);
        queue_cmd(8'($urandom), 8'($urandom), 16'($urandom), 7'd0, 0);
    endtask

    task automatic random_burst(input int n);
        int target;
        int pick;
        int len;
        int f;
        target = req_backlog.size() + n;
        while (req_backlog.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                len = roll(3) ? SE_MAX_DATA : $urandom_range(0, 6);
                queue_cmd(8'($urandom), 8'($urandom), 16'($urandom), 7'(len),
                          roll(10) ? $urandom_range(0, len) : len);
            end else if (pick < 80) begin
                len = roll(3) ? SE_MAX_DATA : $urandom_range(0, 6);
                f = $urandom_range(0, 99);
                if (f < 70) queue_rsp(7'(len), FLAW_NONE, FULL);
                else if (f < 80) queue_rsp(7'(len), FLAW_COUNT, FULL);
                else if (f < 88) queue_rsp(7'(len), FLAW_CRC, FULL);
                else if (f < 94) queue_rsp(7'(len), FLAW_BOTH, FULL);
                else queue_rsp(7'(len), FLAW_NONE, $urandom_range(0, len + 2));
            end else begin
                req_backlog.push_back(mk_word(2'($urandom_range(0, 3))));
            end
        end
    endtask

    task automatic drain();
        while (req_backlog.size() != 0 || req_ch.valid || owed_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    initial begin
        int send_pct[4];
        int recv_pct[4];
        int ph;
        send_pct = '{0, 55, 0, 16};
        recv_pct = '{0, 0, 55, 16};
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.func      = FUNC_START_CMD;
        req_ch.opcode    = '0;
        req_ch.param_one = '0;
        req_ch.param_two = '0;
        req_ch.data_len  = '0;
        req_ch.resp_len  = '0;
        req_ch.in_byte   = '0;
        res_ch.ready     = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        queue_directed();
        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            random_burst(18);
            drain();
        end
        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/sepf_pkg.sv
rtl/core/sepf_if.sv
rtl/core/secure_element_packet_framer_core.sv
tb/tb_secure_element_packet_framer_core.sv
